>>> rtl/core/sdc_pkg.sv
// Shared types, codes and helpers for the STORE DATA chaining engine.
`timescale 1ns / 1ps

package sdc_pkg;

    // Largest number of data bytes in one STORE DATA frame.
    localparam logic [7:0] MAX_BLOCK = 8'd255;

    // Room for the words that one input item can produce (at most six), and the counter width for them.
    localparam int SDC_MAX_BURST = 7;
    localparam int SDC_CNT_W     = 3;

    // Input item kinds.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_REQ   = 2'd1;
    localparam logic [1:0] KIND_RESP  = 2'd2;

    // Result destinations.
    localparam logic [1:0] DEST_CARD   = 2'd0;
    localparam logic [1:0] DEST_HOST   = 2'd1;
    localparam logic [1:0] DEST_STATUS = 2'd2;

    // Final outcomes.
    localparam logic [1:0] OUT_OK        = 2'd0;
    localparam logic [1:0] OUT_REFUSED   = 2'd1;
    localparam logic [1:0] OUT_TRANSPORT = 2'd2;

    // Exchange phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEND = 2'd1;
    localparam logic [1:0] PH_MID  = 2'd2;
    localparam logic [1:0] PH_LAST = 2'd3;

    // APDU header bytes and status words.
    localparam logic [7:0]  APDU_CLA_STORE = 8'h80;
    localparam logic [7:0]  APDU_INS_STORE = 8'hE2;
    localparam logic [7:0]  APDU_P1_MORE   = 8'h11;
    localparam logic [7:0]  APDU_P1_LAST   = 8'h91;
    localparam logic [7:0]  APDU_INS_GETR  = 8'hC0;
    localparam logic [7:0]  APDU_ZERO      = 8'h00;
    localparam logic [15:0] SW_OK          = 16'h9000;
    localparam logic [7:0]  SW1_MORE_DATA  = 8'h61;

    // Saturation limit of the response byte counter.
    localparam logic [8:0] RESP_CNT_MAX = 9'd511;

    // One input word as it sits in the queue.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] request_length;
        logic        card_end;
    } t_item;

    // One result word.
    typedef struct packed {
        logic [1:0]  dest;
        logic [7:0]  out_byte;
        logic        out_last;
        logic [1:0]  outcome;
        logic [15:0] status_word;
    } t_res;

    // All result words caused by one input word.
    typedef struct packed {
        t_res [SDC_MAX_BURST-1:0] words;
        logic [SDC_CNT_W-1:0]     count;
    } t_burst;

    // Builds a result word.
    function automatic t_res mk_res(input logic [1:0] dest, input logic [7:0] byte_v,
                                    input logic last, input logic [1:0] outcome,
                                    input logic [15:0] sw);
        t_res r;
        r.dest        = dest;
        r.out_byte    = byte_v;
        r.out_last    = last;
        r.outcome     = outcome;
        r.status_word = sw;
        return r;
    endfunction

endpackage

>>> rtl/core/sdc_in_queue.sv
// Two-entry input queue that decouples the input ready from the output side.
`timescale 1ns / 1ps

module sdc_in_queue
    import sdc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_not_full,
    input  logic  i_pop,
    output logic  o_head_valid,
    output t_item o_head
);

    t_item       r_q [2];
    logic        r_head;
    logic [1:0]  r_cnt;
    logic        n_head;
    logic [1:0]  n_cnt;
    logic        tail;

    assign tail         = r_head ^ r_cnt[0];
    assign o_not_full   = (r_cnt != 2'd2);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_head];

    // Pointer and fill count update.
    always_comb begin
        n_head = r_head;
        n_cnt  = r_cnt;
        if (i_pop) begin
            n_head = ~r_head;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[tail] <= i_item;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("input queue count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0)
        else $error("pop from empty input queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt != 2'd2)
        else $error("push into full input queue");

endmodule

>>> rtl/core/sdc_engine.sv
// Exchange state and the per-word logic that builds each burst of results.
`timescale 1ns / 1ps

module sdc_engine
    import sdc_pkg::*;
#(
    parameter logic [7:0] P_MAX_BLOCK = MAX_BLOCK
)
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_take,
    input  t_item  i_item,
    output t_burst o_burst
);

    logic [1:0]  r_phase,  n_phase;
    logic [15:0] r_rem,    n_rem;
    logic [7:0]  r_chunk,  n_chunk;
    logic [7:0]  r_blk,    n_blk;
    logic [8:0]  r_rcount, n_rcount;
    logic [7:0]  r_held0,  n_held0;
    logic [7:0]  r_held1,  n_held1;

    // Burst assembly and next state for the word at the queue head.
    always_comb begin
        logic [SDC_CNT_W-1:0] k;
        logic [15:0] hdr_rem;
        logic [7:0]  hdr_blk;
        logic [7:0]  hdr_chunk;
        logic        hdr_last;
        logic        do_hdr;
        logic        do_fin;
        logic [1:0]  fin_outcome;
        logic [15:0] fin_sw;
        logic [15:0] sw;
        logic [8:0]  cnt_next;

        n_phase     = r_phase;
        n_rem       = r_rem;
        n_chunk     = r_chunk;
        n_blk       = r_blk;
        n_rcount    = r_rcount;
        n_held0     = r_held0;
        n_held1     = r_held1;
        o_burst     = '0;
        k           = '0;
        hdr_rem     = r_rem;
        hdr_blk     = r_blk;
        do_hdr      = 1'b0;
        do_fin      = 1'b0;
        fin_outcome = OUT_OK;
        fin_sw      = 16'd0;
        sw          = {r_held1, i_item.data_byte};
        cnt_next    = (r_rcount == RESP_CNT_MAX) ? r_rcount : r_rcount + 9'd1;

        case (i_item.kind)
            KIND_START: begin
                n_rem   = i_item.request_length;
                hdr_rem = i_item.request_length;
                hdr_blk = 8'd0;
                do_hdr  = 1'b1;
            end
            KIND_REQ: begin
                // Data byte of the current frame; the Le byte closes the frame.
                if (r_phase == PH_SEND && r_chunk != 8'd0 && r_rem != 16'd0) begin
                    o_burst.words[k] = mk_res(DEST_CARD, i_item.data_byte, 1'b0,
                                              OUT_OK, 16'd0);
                    k       = k + 1'b1;
                    n_chunk = r_chunk - 8'd1;
                    n_rem   = r_rem - 16'd1;
                    if (r_chunk == 8'd1) begin
                        o_burst.words[k] = mk_res(DEST_CARD, APDU_ZERO, 1'b1,
                                                  OUT_OK, 16'd0);
                        k       = k + 1'b1;
                        n_phase = (r_rem == 16'd1) ? PH_LAST : PH_MID;
                    end
                end
            end
            KIND_RESP: begin
                if (r_phase == PH_MID || r_phase == PH_LAST) begin
                    // Forward the byte that has dropped out of the status window.
                    if (r_phase == PH_LAST && r_rcount >= 9'd2) begin
                        o_burst.words[k] = mk_res(DEST_HOST, r_held0, 1'b0,
                                                  OUT_OK, 16'd0);
                        k = k + 1'b1;
                    end
                    n_held0  = r_held1;
                    n_held1  = i_item.data_byte;
                    n_rcount = cnt_next;
                    if (i_item.card_end) begin
                        if (cnt_next < 9'd2) begin
                            do_fin      = 1'b1;
                            fin_outcome = OUT_TRANSPORT;
                        end else if (r_phase == PH_MID) begin
                            if (cnt_next != 9'd2 || sw != SW_OK) begin
                                do_fin      = 1'b1;
                                fin_outcome = OUT_REFUSED;
                                fin_sw      = sw;
                            end else begin
                                hdr_rem = r_rem;
                                hdr_blk = r_blk;
                                do_hdr  = 1'b1;
                            end
                        end else if (sw[15:8] == SW1_MORE_DATA) begin
                            // GET RESPONSE for the remaining answer bytes.
                            o_burst.words[k] = mk_res(DEST_CARD, APDU_ZERO, 1'b0,
                                                      OUT_OK, 16'd0);
                            k = k + 1'b1;
                            o_burst.words[k] = mk_res(DEST_CARD, APDU_INS_GETR, 1'b0,
                                                      OUT_OK, 16'd0);
                            k = k + 1'b1;
                            o_burst.words[k] = mk_res(DEST_CARD, APDU_ZERO, 1'b0,
                                                      OUT_OK, 16'd0);
                            k = k + 1'b1;
                            o_burst.words[k] = mk_res(DEST_CARD, APDU_ZERO, 1'b0,
                                                      OUT_OK, 16'd0);
                            k = k + 1'b1;
                            o_burst.words[k] = mk_res(DEST_CARD, sw[7:0], 1'b1,
                                                      OUT_OK, 16'd0);
                            k = k + 1'b1;
                            n_rcount = 9'd0;
                            n_held0  = 8'd0;
                            n_held1  = 8'd0;
                        end else if (sw == SW_OK) begin
                            do_fin      = 1'b1;
                            fin_outcome = OUT_OK;
                        end else begin
                            do_fin      = 1'b1;
                            fin_outcome = OUT_REFUSED;
                            fin_sw      = sw;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // STORE DATA header for the next block.
        hdr_last  = (hdr_rem <= {8'd0, P_MAX_BLOCK});
        hdr_chunk = hdr_last ? hdr_rem[7:0] : P_MAX_BLOCK;
        if (do_hdr) begin
            o_burst.words[k] = mk_res(DEST_CARD, APDU_CLA_STORE, 1'b0, OUT_OK, 16'd0);
            k = k + 1'b1;
            o_burst.words[k] = mk_res(DEST_CARD, APDU_INS_STORE, 1'b0, OUT_OK, 16'd0);
            k = k + 1'b1;
            o_burst.words[k] = mk_res(DEST_CARD, hdr_last ? APDU_P1_LAST : APDU_P1_MORE,
                                      1'b0, OUT_OK, 16'd0);
            k = k + 1'b1;
            o_burst.words[k] = mk_res(DEST_CARD, hdr_blk, 1'b0, OUT_OK, 16'd0);
            k = k + 1'b1;
            o_burst.words[k] = mk_res(DEST_CARD, hdr_chunk, 1'b0, OUT_OK, 16'd0);
            k = k + 1'b1;
            n_blk    = hdr_blk + 8'd1;
            n_chunk  = hdr_chunk;
            n_rcount = 9'd0;
            n_held0  = 8'd0;
            n_held1  = 8'd0;
            // An empty request goes out as a whole frame at once.
            if (hdr_chunk == 8'd0) begin
                o_burst.words[k] = mk_res(DEST_CARD, APDU_ZERO, 1'b1, OUT_OK, 16'd0);
                k       = k + 1'b1;
                n_phase = PH_LAST;
            end else begin
                n_phase = PH_SEND;
            end
        end

        // Final status word ends the exchange.
        if (do_fin) begin
            o_burst.words[k] = mk_res(DEST_STATUS, 8'd0, 1'b1, fin_outcome, fin_sw);
            k        = k + 1'b1;
            n_phase  = PH_IDLE;
            n_rem    = 16'd0;
            n_chunk  = 8'd0;
            n_rcount = 9'd0;
            n_held0  = 8'd0;
            n_held1  = 8'd0;
        end

        o_burst.count = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_rem    <= 16'd0;
            r_chunk  <= 8'd0;
            r_blk    <= 8'd0;
            r_rcount <= 9'd0;
            r_held0  <= 8'd0;
            r_held1  <= 8'd0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_rem    <= n_rem;
            r_chunk  <= n_chunk;
            r_blk    <= n_blk;
            r_rcount <= n_rcount;
            r_held0  <= n_held0;
            r_held1  <= n_held1;
        end
    end

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_rem == 16'd0 && r_chunk == 8'd0)
        else $error("idle phase with request bytes outstanding");

    a_send_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SEND |-> r_chunk != 8'd0 && {8'd0, r_chunk} <= r_rem)
        else $error("frame data count exceeds remaining request bytes");

    a_burst_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> o_burst.count < 3'd7)
        else $error("burst larger than the result buffer");

endmodule

>>> rtl/core/sdc_emitter.sv
// Result buffer that holds one burst and hands its words out one per cycle while the receiver is ready.
`timescale 1ns / 1ps

module sdc_emitter
    import sdc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_burst i_burst,
    output logic   o_free,
    output logic   o_valid,
    input  logic   i_ready,
    output t_res   o_word
);

    t_res [SDC_MAX_BURST-1:0] r_words;
    logic [SDC_CNT_W-1:0]     r_cnt;
    logic [SDC_CNT_W-1:0]     r_idx;
    logic [SDC_CNT_W-1:0]     idx_inc;

    assign idx_inc = r_idx + 1'b1;
    assign o_valid = (r_idx != r_cnt);
    assign o_word  = r_words[r_idx];
    // The buffer can take a new burst once its last word leaves.
    assign o_free  = !o_valid || (i_ready && idx_inc == r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
            r_idx <= '0;
        end else if (o_valid && i_ready) begin
            r_idx <= idx_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_words <= i_burst.words;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("burst loaded over words not yet delivered");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_cnt)
        else $error("result index past burst length");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.dest == DEST_STATUS |-> o_word.out_last)
        else $error("status word without last flag");

endmodule

>>> rtl/core/apdu_store_data_chaining_engine.sv
// Top level of the STORE DATA chaining engine with GET RESPONSE collection.
`timescale 1ns / 1ps

// Usage:
// The input channel (i_in_valid / o_in_ready) carries one word per handshake:
// a start word with the request length, request bytes from the host, or card
// response bytes with i_card_end on the final byte of each card response.
// The output channel (o_out_valid / i_out_ready) carries command bytes for the
// card, answer bytes for the host and one final status word per exchange.
// An input word enters a two-entry queue; the engine takes it from the queue
// head once the result buffer is free and loads its whole burst of results
// (zero to six words) into the result buffer, which shows the words in order.
// The result buffer hands out one word per cycle while the receiver is ready,
// so the rate is one input word per cycle when each word yields at most one
// result; a word that yields more results holds the engine until its last
// result leaves through the single output port.
// When the receiver stalls, the buffer holds its word, the engine waits, and
// o_in_ready drops once both queue entries are full.
// Reset empties the queue and the result buffer and returns the exchange to
// idle with block number zero.

module apdu_store_data_chaining_engine
    import sdc_pkg::*;
#(
    parameter logic [7:0] P_MAX_BLOCK = MAX_BLOCK
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_request_length,
    input  logic        i_card_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_dest,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [1:0]  o_outcome,
    output logic [15:0] o_status_word
);

    t_item  in_item;
    t_item  head;
    logic   head_valid;
    logic   take;
    logic   buf_free;
    t_burst burst;
    t_res   word;

    assign in_item.kind           = i_kind;
    assign in_item.data_byte      = i_data_byte;
    assign in_item.request_length = i_request_length;
    assign in_item.card_end       = i_card_end;

    // The engine works on the head word when the result buffer can take its burst.
    assign take = head_valid && buf_free;

    sdc_in_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_in_valid && o_in_ready),
        .i_item       (in_item),
        .o_not_full   (o_in_ready),
        .i_pop        (take),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    sdc_engine #(
        .P_MAX_BLOCK (P_MAX_BLOCK)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (head),
        .o_burst (burst)
    );

    sdc_emitter u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_burst (burst),
        .o_free  (buf_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (word)
    );

    assign o_dest        = word.dest;
    assign o_out_byte    = word.out_byte;
    assign o_out_last    = word.out_last;
    assign o_outcome     = word.outcome;
    assign o_status_word = word.status_word;

    a_outcome_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dest != DEST_STATUS |-> o_outcome == OUT_OK)
        else $error("outcome set on a data word");

    a_sw_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status_word != 16'd0 |-> o_outcome == OUT_REFUSED)
        else $error("status word reported without refusal");

    a_host_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dest == DEST_HOST |-> !o_out_last)
        else $error("answer byte flagged as last");

endmodule
